/* rtl/bpa_pkg.sv */
// Shared types, constants and helpers for the buddy page allocator.
// Used by bpa_ctrl, bpa_dpath and buddy_page_allocator_top; depends on nothing.
package bpa_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int NUM_ORDERS = 11;
	localparam int PAGE_W     = 12;
	localparam int LINK_W     = 13;
	localparam int ORD_W      = 4;
	localparam int CNT_W      = 13;
	localparam int SIZE_W     = 11;
	localparam int STEP_W     = 13;
	localparam int PNUM_W     = 20;
	localparam int PCNT_W     = 21;
	localparam int FUNC_W     = 2;
	localparam int STS_W      = 3;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);
	localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

	localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

	typedef enum logic [STS_W-1:0] {
		STS_OK, STS_NOMEM, STS_BAD_ORDER, STS_BAD_PAGE,
		STS_RESERVED, STS_DOUBLE_FREE, STS_ORDER_MISMATCH, STS_CORRUPT
	} sts_t;

	typedef struct packed {
		logic [ORD_W-1:0]  order;
		logic              free;
		logic              rsv;
		logic [LINK_W-1:0] link;
	} ent_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_ADD_PICK, S_ADD_WR, S_POP_CHK, S_POP_UPD,
		S_SPLIT, S_FR_CHK, S_MRG_CHK, S_BUD_CHK, S_WALK_CHK, S_WALK_STEP,
		S_UNLINK, S_UNL_BUD, S_PUSH, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_LOAD, OP_ADD_PICK, OP_ADD_WR, OP_AL_START,
		OP_POP_NULL, OP_POP_RD, OP_POP_UPD, OP_SPLIT, OP_AL_FIN, OP_FR_RD,
		OP_BUD_RD, OP_WALK_INIT, OP_WALK_RD, OP_WALK_STEP, OP_UNLINK,
		OP_UNL_BUD, OP_FR_PUSH, OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		sts_t code;
	} cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic [FUNC_W-1:0] func;
		logic              ord_bad;
		logic              pg_bad;
		logic              add_more;
		logic              add_last;
		logic              al_none;
		logic              pop_null;
		logic              pop_free;
		logic              split_more;
		logic              ent_rsv;
		logic              ent_free;
		logic              ord_mis;
		logic              merge_ok;
		logic              bud_ok;
		logic              walk_end;
		logic              walk_hit;
		logic              cnt_ovf;
		logic              out_busy;
	} flags_t;

	function automatic ent_t mk_ent(logic [ORD_W-1:0] o, logic f, logic r,
			logic [LINK_W-1:0] l);
		ent_t e;
		e.order = o;
		e.free  = f;
		e.rsv   = r;
		e.link  = l;
		return e;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a,
			logic [SIZE_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W+1)'(b);
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

/* rtl/bpa_ctrl.sv */
// Sequencing state machine of the buddy page allocator.
// Depends on bpa_pkg; drives commands into bpa_dpath and reads its flags.
module bpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bpa_pkg::flags_t flags,
	output bpa_pkg::cmd_t   cmd
);
	import bpa_pkg::*;

	state_t state_q, state_d;
	sts_t   code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= STS_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			S_CLEAR: begin
				if (flags.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_DONE;
				code_d  = STS_OK;
				case (flags.func)
					FN_ADD: state_d = S_ADD_PICK;
					FN_ALLOC: begin
						if (flags.ord_bad)
							code_d = STS_BAD_ORDER;
						else if (flags.al_none)
							code_d = STS_NOMEM;
						else
							state_d = S_POP_CHK;
					end
					FN_FREE: begin
						if (flags.ord_bad)
							code_d = STS_BAD_ORDER;
						else if (flags.pg_bad)
							code_d = STS_BAD_PAGE;
						else
							state_d = S_FR_CHK;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ADD_PICK: begin
				if (!flags.add_more)
					state_d = S_DONE;
				else
					state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				if (flags.add_last)
					state_d = S_ADD_PICK;
			end
			S_POP_CHK: begin
				if (flags.pop_null) begin
					state_d = S_DONE;
					code_d  = STS_CORRUPT;
				end else begin
					state_d = S_POP_UPD;
				end
			end
			S_POP_UPD: state_d = flags.pop_free ? S_SPLIT : S_POP_CHK;
			S_SPLIT: begin
				if (!flags.split_more)
					state_d = S_DONE;
			end
			S_FR_CHK: begin
				state_d = S_DONE;
				if (flags.ent_rsv)
					code_d = STS_RESERVED;
				else if (flags.ent_free)
					code_d = STS_DOUBLE_FREE;
				else if (flags.ord_mis)
					code_d = STS_ORDER_MISMATCH;
				else
					state_d = S_MRG_CHK;
			end
			S_MRG_CHK: state_d = flags.merge_ok ? S_BUD_CHK : S_PUSH;
			S_BUD_CHK: state_d = flags.bud_ok ? S_WALK_CHK : S_PUSH;
			S_WALK_CHK: begin
				if (flags.walk_end)
					state_d = S_PUSH;
				else if (flags.walk_hit)
					state_d = S_UNLINK;
				else
					state_d = S_WALK_STEP;
			end
			S_WALK_STEP: state_d = S_WALK_CHK;
			S_UNLINK: state_d = S_UNL_BUD;
			S_UNL_BUD: state_d = S_MRG_CHK;
			S_PUSH: begin
				state_d = S_DONE;
				code_d  = flags.cnt_ovf ? STS_CORRUPT : STS_OK;
			end
			S_DONE: begin
				if (!flags.out_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.code  = code_q;
		req_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: cmd.op = OP_CLEAR;
			S_IDLE: begin
				if (req_valid)
					cmd.op = OP_LOAD;
			end
			S_DECODE: begin
				if (flags.func == FN_ALLOC && !flags.ord_bad && !flags.al_none)
					cmd.op = OP_AL_START;
				else if (flags.func == FN_FREE && !flags.ord_bad && !flags.pg_bad)
					cmd.op = OP_FR_RD;
			end
			S_ADD_PICK: begin
				if (flags.add_more)
					cmd.op = OP_ADD_PICK;
			end
			S_ADD_WR: cmd.op = OP_ADD_WR;
			S_POP_CHK: cmd.op = flags.pop_null ? OP_POP_NULL : OP_POP_RD;
			S_POP_UPD: cmd.op = OP_POP_UPD;
			S_SPLIT: cmd.op = flags.split_more ? OP_SPLIT : OP_AL_FIN;
			S_MRG_CHK: begin
				if (flags.merge_ok)
					cmd.op = OP_BUD_RD;
			end
			S_BUD_CHK: begin
				if (flags.bud_ok)
					cmd.op = OP_WALK_INIT;
			end
			S_WALK_CHK: begin
				if (!flags.walk_end && !flags.walk_hit)
					cmd.op = OP_WALK_RD;
			end
			S_WALK_STEP: cmd.op = OP_WALK_STEP;
			S_UNLINK: cmd.op = OP_UNLINK;
			S_UNL_BUD: cmd.op = OP_UNL_BUD;
			S_PUSH: cmd.op = OP_FR_PUSH;
			S_DONE: begin
				if (!flags.out_busy)
					cmd.op = OP_OUT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

/* rtl/bpa_dpath.sv */
// Datapath of the buddy page allocator: page table memory, list heads,
// counters, walk registers and the result register. Depends on bpa_pkg.
module bpa_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpa_pkg::cmd_t              cmd,
	output bpa_pkg::flags_t            flags,
	input  logic [bpa_pkg::FUNC_W-1:0] func,
	input  logic [bpa_pkg::PNUM_W-1:0] page_number,
	input  logic [bpa_pkg::PCNT_W-1:0] page_count,
	input  logic [bpa_pkg::ORD_W-1:0]  block_order,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [bpa_pkg::STS_W-1:0]  status,
	output logic [bpa_pkg::PAGE_W-1:0] alloc_page,
	output logic [bpa_pkg::CNT_W-1:0]  total_count,
	output logic [bpa_pkg::CNT_W-1:0]  free_total
);
	import bpa_pkg::*;

	ent_t               mem [NUM_PAGES];
	ent_t               rd_q;
	logic [LINK_W-1:0]  head_q [NUM_ORDERS];
	logic [CNT_W-1:0]   usable_q, free_q;
	logic [FUNC_W-1:0]  func_q;
	logic [PNUM_W-1:0]  pnum_q;
	logic [ORD_W-1:0]   ord_q, aord_q, o_q, cur_q;
	logic [LINK_W-1:0]  pfn_q, end_q, c_q, prev_q;
	logic [PAGE_W-1:0]  bud_q, clr_q;
	logic [SIZE_W-1:0]  idx_q;
	logic [STEP_W-1:0]  steps_q;
	ent_t               prev_ent_q, bud_ent_q;
	logic               rsp_valid_q;
	logic [STS_W-1:0]   status_q;
	logic [PAGE_W-1:0]  alloc_page_q;
	logic [CNT_W-1:0]   total_q, free_total_q;

	logic               mem_we, mem_re;
	logic [PAGE_W-1:0]  mem_waddr, mem_raddr;
	ent_t               mem_wdata;

	logic [PCNT_W:0]    load_sum;
	logic [LINK_W-1:0]  load_end;
	logic [ORD_W-1:0]   pick_ord, al_ord, o_dec;
	logic               al_none;
	logic [SIZE_W-1:0]  add_size, req_size;
	logic [PAGE_W-1:0]  split_bud, mrg_bud;
	logic [CNT_W:0]     free_nf;

	assign load_sum  = (PCNT_W+1)'(page_number) + (PCNT_W+1)'(page_count);
	assign load_end  = (load_sum > NUM_PAGES) ? NULL_LINK : load_sum[LINK_W-1:0];
	assign add_size  = SIZE_W'(1) << aord_q;
	assign req_size  = SIZE_W'(1) << ord_q;
	assign o_dec     = o_q - ORD_W'(1);
	assign split_bud = pfn_q[PAGE_W-1:0] ^ (PAGE_W'(1) << o_dec);
	assign mrg_bud   = pfn_q[PAGE_W-1:0] ^ (PAGE_W'(1) << cur_q);
	assign free_nf   = {1'b0, free_q} + (CNT_W+1)'(req_size);

	// Largest aligned block that starts at the cursor and fits the region.
	always_comb begin
		pick_ord = '0;
		for (int k = 1; k < NUM_ORDERS; k++) begin
			if ((pfn_q & LINK_W'((1 << k) - 1)) == '0 &&
					({1'b0, pfn_q} + (LINK_W+1)'(1 << k)) <= {1'b0, end_q})
				pick_ord = ORD_W'(k);
		end
	end

	// Smallest non-empty order at or above the request.
	always_comb begin
		al_ord  = '0;
		al_none = 1'b1;
		for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
			if (ORD_W'(k) >= ord_q && head_q[k] < NULL_LINK) begin
				al_ord  = ORD_W'(k);
				al_none = 1'b0;
			end
		end
	end

	always_comb begin
		flags.clr_last   = (clr_q == PAGE_W'(NUM_PAGES - 1));
		flags.func       = func_q;
		flags.ord_bad    = (ord_q >= NUM_ORDERS);
		flags.pg_bad     = (pnum_q >= NUM_PAGES);
		flags.add_more   = (pnum_q < NUM_PAGES) && (pfn_q < end_q);
		flags.add_last   = (idx_q == add_size - SIZE_W'(1));
		flags.al_none    = al_none;
		flags.pop_null   = (head_q[o_q] >= NULL_LINK) || (steps_q > NUM_PAGES);
		flags.pop_free   = rd_q.free;
		flags.split_more = (o_q > ord_q);
		flags.ent_rsv    = rd_q.rsv;
		flags.ent_free   = rd_q.free;
		flags.ord_mis    = (rd_q.order != ord_q);
		flags.merge_ok   = (cur_q < NUM_ORDERS - 1);
		flags.bud_ok     = rd_q.free && (rd_q.order == cur_q);
		flags.walk_end   = (c_q >= NULL_LINK) || (steps_q > NUM_PAGES);
		flags.walk_hit   = (c_q == {1'b0, bud_q});
		flags.cnt_ovf    = (free_nf > {1'b0, usable_q});
		flags.out_busy   = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = pfn_q[PAGE_W-1:0];
		mem_raddr = pfn_q[PAGE_W-1:0];
		mem_wdata = mk_ent('0, 1'b0, 1'b0, NULL_LINK);
		case (cmd.op)
			OP_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = mk_ent('0, 1'b0, 1'b1, NULL_LINK);
			end
			OP_ADD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pfn_q[PAGE_W-1:0] + PAGE_W'(idx_q);
				if (idx_q == '0)
					mem_wdata = mk_ent(aord_q, 1'b1, 1'b0, head_q[aord_q]);
			end
			OP_POP_RD: begin
				mem_re    = 1'b1;
				mem_raddr = head_q[o_q][PAGE_W-1:0];
			end
			OP_POP_UPD: begin
				mem_we    = !rd_q.free;
				mem_wdata = mk_ent(rd_q.order, 1'b0, rd_q.rsv, NULL_LINK);
			end
			OP_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = split_bud;
				mem_wdata = mk_ent(o_dec, 1'b1, 1'b0, head_q[o_dec]);
			end
			OP_AL_FIN: begin
				mem_we    = 1'b1;
				mem_wdata = mk_ent(ord_q, 1'b0, 1'b0, NULL_LINK);
			end
			OP_FR_RD: begin
				mem_re    = 1'b1;
				mem_raddr = pnum_q[PAGE_W-1:0];
			end
			OP_BUD_RD: begin
				mem_re    = 1'b1;
				mem_raddr = mrg_bud;
			end
			OP_WALK_RD: begin
				mem_re    = 1'b1;
				mem_raddr = c_q[PAGE_W-1:0];
			end
			OP_UNLINK: begin
				mem_we    = (prev_q != NULL_LINK);
				mem_waddr = prev_q[PAGE_W-1:0];
				mem_wdata = mk_ent(prev_ent_q.order, prev_ent_q.free, prev_ent_q.rsv,
					bud_ent_q.link);
			end
			OP_UNL_BUD: begin
				mem_we    = 1'b1;
				mem_waddr = bud_q;
				mem_wdata = mk_ent(bud_ent_q.order, bud_ent_q.free, bud_ent_q.rsv,
					NULL_LINK);
			end
			OP_FR_PUSH: begin
				mem_we    = 1'b1;
				mem_wdata = mk_ent(cur_q, 1'b1, 1'b0, head_q[cur_q]);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ORDERS; k++)
				head_q[k] <= NULL_LINK;
			usable_q     <= '0;
			free_q       <= '0;
			func_q       <= '0;
			pnum_q       <= '0;
			ord_q        <= '0;
			aord_q       <= '0;
			o_q          <= '0;
			cur_q        <= '0;
			pfn_q        <= '0;
			end_q        <= '0;
			c_q          <= NULL_LINK;
			prev_q       <= NULL_LINK;
			bud_q        <= '0;
			clr_q        <= '0;
			idx_q        <= '0;
			steps_q      <= '0;
			prev_ent_q   <= '0;
			bud_ent_q    <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= '0;
			alloc_page_q <= '0;
			total_q      <= '0;
			free_total_q <= '0;
		end else begin
			if (cmd.op == OP_OUT)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + PAGE_W'(1);
				OP_LOAD: begin
					func_q <= func;
					pnum_q <= page_number;
					ord_q  <= block_order;
					pfn_q  <= {1'b0, page_number[PAGE_W-1:0]};
					end_q  <= load_end;
				end
				OP_ADD_PICK: begin
					aord_q <= pick_ord;
					idx_q  <= '0;
				end
				OP_ADD_WR: begin
					if (idx_q == '0)
						head_q[aord_q] <= pfn_q;
					if (flags.add_last) begin
						usable_q <= sat_add(usable_q, add_size);
						free_q   <= sat_add(free_q, add_size);
						pfn_q    <= pfn_q + LINK_W'(add_size);
					end else begin
						idx_q <= idx_q + SIZE_W'(1);
					end
				end
				OP_AL_START: begin
					o_q     <= al_ord;
					steps_q <= '0;
				end
				OP_POP_NULL: head_q[o_q] <= NULL_LINK;
				OP_POP_RD: begin
					pfn_q   <= head_q[o_q];
					steps_q <= steps_q + STEP_W'(1);
				end
				OP_POP_UPD: head_q[o_q] <= rd_q.link;
				OP_SPLIT: begin
					head_q[o_dec] <= {1'b0, split_bud};
					o_q           <= o_dec;
				end
				OP_AL_FIN: begin
					free_q <= (free_q > CNT_W'(req_size)) ? free_q - CNT_W'(req_size) : '0;
				end
				OP_FR_RD: cur_q <= ord_q;
				OP_BUD_RD: bud_q <= mrg_bud;
				OP_WALK_INIT: begin
					bud_ent_q <= rd_q;
					c_q       <= head_q[cur_q];
					prev_q    <= NULL_LINK;
					steps_q   <= '0;
				end
				OP_WALK_RD: begin
					prev_q  <= c_q;
					steps_q <= steps_q + STEP_W'(1);
				end
				OP_WALK_STEP: begin
					prev_ent_q <= rd_q;
					c_q        <= rd_q.link;
				end
				OP_UNLINK: begin
					if (prev_q == NULL_LINK)
						head_q[cur_q] <= bud_ent_q.link;
				end
				OP_UNL_BUD: begin
					if ({1'b0, bud_q} < pfn_q)
						pfn_q <= {1'b0, bud_q};
					cur_q <= cur_q + ORD_W'(1);
				end
				OP_FR_PUSH: begin
					head_q[cur_q] <= pfn_q;
					if (!flags.cnt_ovf)
						free_q <= free_nf[CNT_W-1:0];
				end
				OP_OUT: begin
					status_q     <= cmd.code;
					alloc_page_q <= (func_q == FN_ALLOC && cmd.code == STS_OK) ?
						pfn_q[PAGE_W-1:0] : '0;
					total_q      <= usable_q;
					free_total_q <= free_q;
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign alloc_page  = alloc_page_q;
	assign total_count = total_q;
	assign free_total  = free_total_q;

`ifndef NO_ASSERTIONS
	a_free_le_usable: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= usable_q) else $error("free count exceeds usable count");
	a_out_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> rsp_valid_q) else $error("result not presented");
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_POP_UPD |-> $past(cmd.op) == OP_POP_RD)
		else $error("pop update without fresh read");
	a_walk_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WALK_STEP |-> $past(cmd.op) == OP_WALK_RD)
		else $error("walk step without fresh read");
`endif

endmodule

/* rtl/buddy_page_allocator_top.sv */
// Top level of the buddy page allocator: joins the controller and datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dpath.
//
// Binary buddy allocator over a 4096-page table with eleven LIFO free lists
// (orders 0 to 10). Each transaction on the request channel is an add-region,
// allocate or free command and produces exactly one transaction on the response
// channel carrying the status, the allocated page on a successful allocate, and
// the usable and free page counts after the command. After reset the block
// marks every page reserved in its page table and holds req_stall high
// during that pass. The page table is a single-ported memory (one write and
// one registered read per cycle), and that port sets the time of each
// command: an add writes every page of each block it carves; an allocate
// reads list heads until it pops a free one, then writes one buddy per split
// level; a free reads and checks the page, then per merge level reads the
// buddy, walks its list past the entries before it and unlinks it, and at
// the end pushes the merged block. Only one command is in progress at a
// time; the result sits in an output register, so a stalled response does
// not hold up the next request until that result is ready to be written.
module buddy_page_allocator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [bpa_pkg::FUNC_W-1:0] func,
	input  logic [bpa_pkg::PNUM_W-1:0] page_number,
	input  logic [bpa_pkg::PCNT_W-1:0] page_count,
	input  logic [bpa_pkg::ORD_W-1:0]  block_order,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [bpa_pkg::STS_W-1:0]  status,
	output logic [bpa_pkg::PAGE_W-1:0] alloc_page,
	output logic [bpa_pkg::CNT_W-1:0]  total_count,
	output logic [bpa_pkg::CNT_W-1:0]  free_total
);
	import bpa_pkg::*;

	// Commands flow from the controller, status flags flow back.
	cmd_t   cmd;
	flags_t flags;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	bpa_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.flags       (flags),
		.func        (func),
		.page_number (page_number),
		.page_count  (page_count),
		.block_order (block_order),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.alloc_page  (alloc_page),
		.total_count (total_count),
		.free_total  (free_total)
	);

endmodule

/* verif/testbench.sv */
// Self-checking testbench for buddy_page_allocator_top: a queue-fed driver, a
// predicting shadow of the page table and a monitor that checks each response.
// Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
	import bpa_pkg::*;

	// Function code with no meaning to the block; it must change nothing.
	localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;
	localparam int COUNT_TOP   = 2 * NUM_PAGES - 1;
	localparam int RANDOM_ITEMS = 1880;
	// A free may walk a full list at every merge level.
	localparam int IDLE_LIMIT  = 500000;

	typedef struct {
		logic [FUNC_W-1:0] fn;
		logic [PNUM_W-1:0] pnum;
		logic [PCNT_W-1:0] pcnt;
		logic [ORD_W-1:0]  ord;
	} command_t;

	typedef struct {
		sts_t              sts;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  free_cnt;
	} outcome_t;

	typedef struct {
		int page;
		int ord;
	} block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [PNUM_W-1:0] page_number = '0;
	logic [PCNT_W-1:0] page_count = '0;
	logic [ORD_W-1:0] block_order = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [STS_W-1:0] status;
	logic [PAGE_W-1:0] alloc_page;
	logic [CNT_W-1:0] total_count;
	logic [CNT_W-1:0] free_total;

	buddy_page_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .page_number(page_number),
		.page_count(page_count), .block_order(block_order),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .alloc_page(alloc_page),
		.total_count(total_count), .free_total(free_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the allocator state, kept up to date as each request
	// transaction is accepted.
	logic [ORD_W-1:0] shadow_order [NUM_PAGES];
	logic             shadow_free  [NUM_PAGES];
	logic             shadow_rsv   [NUM_PAGES];
	int               shadow_link  [NUM_PAGES];
	int               shadow_head  [NUM_ORDERS];
	int               usable_cnt;
	int               free_cnt;

	command_t pending_cmds[$];
	outcome_t awaited_rsps[$];
	block_t   held_blocks[$];

	int  mismatches = 0;
	int  n_add = 0, n_alloc = 0, n_free = 0, n_granted = 0, n_odd = 0;
	bit  no_gaps = 1'b0;
	int  idle_cycles = 0;

	function automatic int sat_count(int a, int b);
		return (a + b > COUNT_TOP) ? COUNT_TOP : a + b;
	endfunction

	function automatic void push_free_block(int ord, int pg);
		shadow_order[pg] = ORD_W'(ord);
		shadow_free[pg]  = 1'b1;
		shadow_rsv[pg]   = 1'b0;
		shadow_link[pg]  = shadow_head[ord];
		shadow_head[ord] = pg;
	endfunction

	// Pops the head of one list, discarding heads that are no longer free.
	function automatic int pop_free_block(int ord);
		int steps = 0;
		int pg;
		while (shadow_head[ord] < NUM_PAGES && steps <= NUM_PAGES) begin
			pg = shadow_head[ord];
			shadow_head[ord] = shadow_link[pg];
			shadow_link[pg] = NUM_PAGES;
			steps++;
			if (shadow_free[pg]) begin
				shadow_free[pg] = 1'b0;
				shadow_rsv[pg] = 1'b0;
				return pg;
			end
		end
		shadow_head[ord] = NUM_PAGES;
		return NUM_PAGES;
	endfunction

	function automatic bit unlink_buddy(int ord, int pg);
		int prev = NUM_PAGES;
		int cur = shadow_head[ord];
		int steps = 0;
		while (cur < NUM_PAGES && steps <= NUM_PAGES) begin
			if (cur == pg) begin
				if (prev == NUM_PAGES)
					shadow_head[ord] = shadow_link[cur];
				else
					shadow_link[prev] = shadow_link[cur];
				shadow_link[cur] = NUM_PAGES;
				return 1'b1;
			end
			prev = cur;
			cur = shadow_link[cur];
			steps++;
		end
		return 1'b0;
	endfunction

	function automatic sts_t add_region(int start, int count);
		int fin = start + count;
		int pfn = start;
		int ord, size;
		if (fin > NUM_PAGES)
			fin = NUM_PAGES;
		while (pfn < fin) begin
			ord = NUM_ORDERS - 1;
			while (ord > 0) begin
				size = 1 << ord;
				if ((pfn & (size - 1)) == 0 && pfn + size <= fin)
					break;
				ord--;
			end
			size = 1 << ord;
			for (int i = 0; i < size; i++) begin
				shadow_order[pfn + i] = '0;
				shadow_free[pfn + i] = 1'b0;
				shadow_rsv[pfn + i] = 1'b0;
				shadow_link[pfn + i] = NUM_PAGES;
			end
			push_free_block(ord, pfn);
			free_cnt = sat_count(free_cnt, size);
			usable_cnt = sat_count(usable_cnt, size);
			pfn += size;
		end
		return STS_OK;
	endfunction

	function automatic sts_t grant_block(int req, output int page);
		int o = req;
		int pg, size;
		page = 0;
		if (req >= NUM_ORDERS)
			return STS_BAD_ORDER;
		while (o < NUM_ORDERS && shadow_head[o] >= NUM_PAGES)
			o++;
		if (o >= NUM_ORDERS)
			return STS_NOMEM;
		pg = pop_free_block(o);
		if (pg >= NUM_PAGES)
			return STS_CORRUPT;
		while (o > req) begin
			o--;
			push_free_block(o, pg ^ (1 << o));
		end
		shadow_order[pg] = ORD_W'(req);
		shadow_free[pg] = 1'b0;
		shadow_rsv[pg] = 1'b0;
		size = 1 << req;
		free_cnt = (free_cnt > size) ? free_cnt - size : 0;
		page = pg;
		return STS_OK;
	endfunction

	function automatic sts_t release_block(int pfn, int ord);
		int pg, cur, bud, nf;
		if (ord >= NUM_ORDERS)
			return STS_BAD_ORDER;
		if (pfn >= NUM_PAGES)
			return STS_BAD_PAGE;
		pg = pfn;
		if (shadow_rsv[pg])
			return STS_RESERVED;
		if (shadow_free[pg])
			return STS_DOUBLE_FREE;
		if (shadow_order[pg] != ORD_W'(ord))
			return STS_ORDER_MISMATCH;
		cur = ord;
		while (cur < NUM_ORDERS - 1) begin
			bud = pg ^ (1 << cur);
			if (bud >= NUM_PAGES)
				break;
			if (!shadow_free[bud] || shadow_order[bud] != ORD_W'(cur))
				break;
			if (!unlink_buddy(cur, bud))
				break;
			if (bud < pg)
				pg = bud;
			cur++;
		end
		push_free_block(cur, pg);
		nf = free_cnt + (1 << ord);
		if (nf > usable_cnt)
			return STS_CORRUPT;
		free_cnt = (nf > COUNT_TOP) ? COUNT_TOP : nf;
		return STS_OK;
	endfunction

	// Works out the response to one accepted command and queues it.
	function automatic void forecast_response(command_t c);
		outcome_t r;
		int pg = 0;
		r.sts = STS_OK;
		case (c.fn)
			FN_ADD: begin
				n_add++;
				r.sts = add_region(int'(c.pnum), int'(c.pcnt));
			end
			FN_ALLOC: begin
				n_alloc++;
				r.sts = grant_block(int'(c.ord), pg);
				if (r.sts == STS_OK) begin
					n_granted++;
					held_blocks.push_back('{page: pg, ord: int'(c.ord)});
				end
			end
			FN_FREE: begin
				n_free++;
				r.sts = release_block(int'(c.pnum), int'(c.ord));
			end
			default: n_odd++;
		endcase
		r.page = (r.sts == STS_OK) ? PAGE_W'(pg) : '0;
		r.total = CNT_W'(usable_cnt);
		r.free_cnt = CNT_W'(free_cnt);
		awaited_rsps.push_back(r);
	endfunction

	// Driver: one command at a time from the pending queue, with a random
	// number of idle cycles drawn after each accepted transaction.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		command_t c;
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap = 0;
		end else begin
			next_valid = req_valid;
			if (req_valid && !req_stall) begin
				c.fn = func;
				c.pnum = page_number;
				c.pcnt = page_count;
				c.ord = block_order;
				forecast_response(c);
				next_valid = 1'b0;
				send_gap = no_gaps ? 0 : $urandom_range(0, 3);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_cmds.size() > 0) begin
					c = pending_cmds.pop_front();
					func <= c.fn;
					page_number <= c.pnum;
					page_count <= c.pcnt;
					block_order <= c.ord;
					next_valid = 1'b1;
				end
			end
			req_valid <= next_valid;
		end
	end

	// Monitor: checks each accepted response against the oldest forecast and
	// throttles the response channel with random stalls.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		outcome_t r;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsps.size() == 0) begin
					$error("response transaction with nothing awaited");
					mismatches++;
				end else begin
					r = awaited_rsps.pop_front();
					if (status !== r.sts) begin
						$error("status: expected %0d, got %0d", r.sts, status);
						mismatches++;
					end
					if (alloc_page !== r.page) begin
						$error("alloc_page: expected %0d, got %0d", r.page, alloc_page);
						mismatches++;
					end
					if (total_count !== r.total) begin
						$error("total_count: expected %0d, got %0d", r.total, total_count);
						mismatches++;
					end
					if (free_total !== r.free_cnt) begin
						$error("free_total: expected %0d, got %0d", r.free_cnt,
							free_total);
						mismatches++;
					end
				end
				stall_left = no_gaps ? 0 : $urandom_range(0, 3);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left > 0);
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic queue_cmd(logic [FUNC_W-1:0] fn, logic [PNUM_W-1:0] pnum,
			logic [PCNT_W-1:0] pcnt, logic [ORD_W-1:0] ord);
		pending_cmds.push_back('{fn: fn, pnum: pnum, pcnt: pcnt, ord: ord});
	endtask

	// Checked at the falling edge, once the driver and monitor have settled.
	task automatic drain_all();
		do
			@(negedge clk);
		while (pending_cmds.size() > 0 || req_valid || awaited_rsps.size() > 0);
	endtask

	// Builds one random command. Most frees return a block that was really
	// granted, so that merges are exercised; the rest are stray or broken.
	task automatic queue_random_cmd();
		int pick, idx;
		logic [PNUM_W-1:0] pnum;
		logic [PCNT_W-1:0] pcnt;
		logic [ORD_W-1:0] ord;
		block_t b;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			ord = ($urandom_range(0, 19) == 0) ? ORD_W'($urandom_range(0, 15))
				: ORD_W'($urandom_range(0, 4));
			queue_cmd(FN_ALLOC, PNUM_W'($urandom), PCNT_W'($urandom), ord);
		end else if (pick < 75) begin
			if (held_blocks.size() > 0 && $urandom_range(0, 9) < 7) begin
				idx = $urandom_range(0, held_blocks.size() - 1);
				b = held_blocks[idx];
				held_blocks.delete(idx);
				queue_cmd(FN_FREE, PNUM_W'(b.page), PCNT_W'($urandom), ORD_W'(b.ord));
			end else begin
				pnum = ($urandom_range(0, 9) == 0) ? PNUM_W'($urandom)
					: PNUM_W'($urandom_range(0, NUM_PAGES - 1));
				queue_cmd(FN_FREE, pnum, PCNT_W'($urandom), ORD_W'($urandom_range(0, 15)));
			end
		end else if (pick < 95) begin
			// Large regions write each of their pages, so they are kept rare.
			if ($urandom_range(0, 49) == 0) begin
				pnum = PNUM_W'($urandom);
				pcnt = PCNT_W'($urandom);
			end else begin
				pnum = PNUM_W'($urandom_range(0, NUM_PAGES - 1));
				pcnt = PCNT_W'($urandom_range(0, 64));
			end
			queue_cmd(FN_ADD, pnum, pcnt, ORD_W'($urandom));
		end else begin
			queue_cmd(FN_NOP, PNUM_W'($urandom), PCNT_W'($urandom), ORD_W'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_PAGES; i++) begin
			shadow_order[i] = '0;
			shadow_free[i] = 1'b0;
			shadow_rsv[i] = 1'b1;
			shadow_link[i] = NUM_PAGES;
		end
		for (int i = 0; i < NUM_ORDERS; i++)
			shadow_head[i] = NUM_PAGES;
		usable_cnt = 0;
		free_cnt = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: an unknown code, requests against an empty table,
		// empty and clipped regions, then the whole table and the error cases.
		no_gaps = 1'b1;
		queue_cmd(FN_NOP, '1, '1, '1);
		queue_cmd(FN_ALLOC, '0, '0, 4'd0);
		queue_cmd(FN_FREE, 20'd5, '0, 4'd0);
		queue_cmd(FN_ADD, 20'd4096, 21'd10, '0);
		queue_cmd(FN_ADD, 20'd0, 21'd0, '0);
		queue_cmd(FN_ADD, '1, 21'd1048576, '0);
		queue_cmd(FN_ADD, 20'd0, 21'd1048576, '0);
		queue_cmd(FN_ALLOC, '0, '0, 4'd10);
		queue_cmd(FN_ALLOC, '0, '0, 4'd0);
		queue_cmd(FN_ALLOC, '0, '0, 4'd15);
		queue_cmd(FN_ALLOC, '0, '0, 4'd11);
		queue_cmd(FN_FREE, 20'd0, '0, 4'd11);
		queue_cmd(FN_FREE, 20'hFFFFF, '0, 4'd0);
		queue_cmd(FN_FREE, 20'd3072, '0, 4'd10);
		queue_cmd(FN_FREE, 20'd3072, '0, 4'd10);
		queue_cmd(FN_FREE, 20'd2048, '0, 4'd5);
		queue_cmd(FN_FREE, 20'd2048, '0, 4'd0);
		queue_cmd(FN_FREE, 20'd4095, '0, 4'd0);
		queue_cmd(FN_ALLOC, '0, '0, 4'd3);
		// Re-adding pages already on lists leaves stale heads behind.
		queue_cmd(FN_ADD, 20'd100, 21'd37, '0);
		queue_cmd(FN_ALLOC, '0, '0, 4'd0);
		queue_cmd(FN_ALLOC, '0, '0, 4'd2);
		queue_cmd(FN_ADD, 20'd4090, 21'd20, '0);
		queue_cmd(FN_ALLOC, '0, '0, 4'd10);
		drain_all();
		no_gaps = 1'b0;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			while (pending_cmds.size() > 1)
				@(posedge clk);
			// Sender holds off until every response is in, now and then.
			if (n % 600 == 300)
				drain_all();
			if (n % 200 == 0)
				no_gaps = ~no_gaps;
			queue_random_cmd();
		end
		drain_all();
		no_gaps = 1'b0;
		repeat (200) @(posedge clk);

		$display("run covered %0d adds, %0d allocations (%0d granted), %0d frees",
			n_add, n_alloc, n_granted, n_free);
		$display("and %0d unknown codes, with random gaps and stalls on both sides",
			n_odd);
		if (mismatches == 0 && awaited_rsps.size() == 0) begin
			$display("end of test: clean");
		end else begin
			if (awaited_rsps.size() > 0)
				$error("%0d responses never arrived", awaited_rsps.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_dpath.sv
rtl/buddy_page_allocator_top.sv
verif/testbench.sv
